[rtl/parallel_port_with_handshake_core_macros.svh]
// ---------------------------------------------------------------------------
// parallel_port_with_handshake_core_macros.svh
// assertion macros for the parallel port core rtl
// ---------------------------------------------------------------------------
`ifndef PARALLEL_PORT_WITH_HANDSHAKE_CORE_MACROS_SVH
`define PARALLEL_PORT_WITH_HANDSHAKE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked check, masked while reset is asserted
`define PPH_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pph assertion failed");

// clocked check that also holds during reset
`define PPH_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pph assertion failed");

`else

`define PPH_ASSERT(label, prop)
`define PPH_ASSERT_ALWAYS(label, prop)

`endif

`endif

[rtl/pph_pkg.sv]
// ---------------------------------------------------------------------------
// pph_pkg
// types and constants for the parallel port with handshake
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pph_pkg;

    // access codes
    typedef enum logic [3:0] {
        ACT_WR_A   = 4'd0,
        ACT_WR_B   = 4'd1,
        ACT_WR_C   = 4'd2,
        ACT_WR_CTL = 4'd3,
        ACT_RD_A   = 4'd4,
        ACT_RD_B   = 4'd5,
        ACT_RD_C   = 4'd6,
        ACT_STROBE = 4'd7,
        ACT_ACK    = 4'd8
    } t_action;

    // group a mode codes
    localparam logic [1:0] MODE_A0 = 2'd0;
    localparam logic [1:0] MODE_A1 = 2'd1;
    localparam logic [1:0] MODE_A2 = 2'd2;

    // mode 2 bit set/reset selectors: handshake enables, port c bit limit
    localparam logic [2:0] SEL_RIE = 3'd4;
    localparam logic [2:0] SEL_WIE = 3'd6;
    localparam logic [2:0] SEL_LIMIT = 3'd3;

    typedef struct packed {
        logic wie;
        logic rie;
        logic obf;
        logic ibf;
        logic rint;
        logic wint;
        logic irq;
    } t_flags;

    localparam t_flags FLAGS_RESET = 7'h10;

    // dir bit: 0 port a, 1 port b, 2 port c low, 3 port c high; 1 = input
    typedef struct packed {
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic [7:0] latch_c;
        logic [7:0] strobe_buf;
        logic [1:0] mode_a;
        logic       mode_b;
        logic [3:0] dir;
        t_flags     flags;
    } t_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic       port_a_written;
        logic       port_b_written;
        logic       port_c_low_written;
        logic       port_c_high_written;
        logic       bit_op_written;
        logic       input_full;
        logic       output_full;
        logic [7:0] port_a_value;
        logic [7:0] port_b_value;
        logic [7:0] port_c_value;
    } t_result;

endpackage

[rtl/pph_access.sv]
// ---------------------------------------------------------------------------
// pph_access
// next state and result of one port access
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pph_access (
    input  pph_pkg::t_state  i_state,
    input  logic [3:0]       i_action,
    input  logic [7:0]       i_data,
    output pph_pkg::t_state  o_state,
    output pph_pkg::t_result o_result
);
    import pph_pkg::*;

    t_state     s;
    t_result    res;
    logic       m2;
    logic [7:0] c1;
    logic [7:0] d1;
    logic [2:0] sel;
    logic       w_int;
    logic       r_int;

    function automatic logic [7:0] set_c_bit(input logic [7:0] c, input logic [7:0] ctl);
        logic [7:0] m;
        m = 8'b1 << ctl[3:1];
        return ctl[0] ? (c | m) : (c & ~m);
    endfunction

    always_comb begin
        s     = i_state;
        res   = '0;
        m2    = (i_state.mode_a == MODE_A2);
        c1    = i_state.latch_c;
        d1    = i_data;
        sel   = i_data[3:1];
        w_int = i_state.flags.obf & i_state.flags.wie;
        r_int = i_state.flags.ibf & i_state.flags.rie;

        case (t_action'(i_action))
            ACT_WR_A: begin
                if (!i_state.dir[0]) begin
                    s.latch_a = i_data;
                    if (m2) begin
                        s.flags.wint = 1'b0;
                        s.flags.obf  = 1'b0;
                    end
                    res.port_a_written = 1'b1;
                end
            end
            ACT_WR_B: begin
                if (!i_state.dir[1]) begin
                    s.latch_b = i_data;
                    res.port_b_written = 1'b1;
                end
            end
            ACT_WR_C: begin
                // handshake modes always pass the low three bits
                if (i_state.mode_a == MODE_A0) begin
                    if (i_state.mode_b) d1 = {i_data[7:4], i_state.latch_c[3:0]};
                end else begin
                    c1 = {i_state.latch_c[7:3], i_data[2:0]};
                    if (i_state.mode_b) d1 = c1;
                end
                s.latch_c = c1;
                if (!i_state.dir[2] && !i_state.mode_b) begin
                    if (i_state.mode_a == MODE_A0) s.latch_c = {c1[7:4], d1[3:0]};
                    else                           s.latch_c = {c1[7:3], d1[2:0]};
                    res.port_c_low_written = 1'b1;
                end
                if (!i_state.dir[3] && i_state.mode_a == MODE_A0) begin
                    s.latch_c = {d1[7:3], s.latch_c[2:0]};
                    res.port_c_high_written = 1'b1;
                end
            end
            ACT_WR_CTL: begin
                if (i_data[7]) begin
                    s.mode_a  = i_data[6] ? MODE_A2 : {1'b0, i_data[5]};
                    s.mode_b  = i_data[2];
                    s.dir     = {i_data[3], i_data[0], i_data[1], i_data[4]};
                    s.latch_a = '0;
                    s.latch_b = '0;
                    s.latch_c = i_data[6] ? 8'h80 : 8'h00;
                end else begin
                    if (m2) begin
                        if (sel == SEL_RIE)        s.flags.rie = i_data[0];
                        else if (sel == SEL_WIE)   s.flags.wie = i_data[0];
                        else if (sel < SEL_LIMIT)  s.latch_c = set_c_bit(i_state.latch_c, i_data);
                    end else begin
                        s.latch_c = set_c_bit(i_state.latch_c, i_data);
                    end
                    res.bit_op_written = 1'b1;
                end
            end
            ACT_RD_A: begin
                if (m2) begin
                    s.flags.rint = 1'b0;
                    if (i_state.flags.ibf) s.latch_a = i_state.strobe_buf;
                    s.flags.ibf = 1'b0;
                end
                res.read_data = s.latch_a;
            end
            ACT_RD_B: begin
                res.read_data = i_state.latch_b;
            end
            ACT_RD_C: begin
                if (m2) begin
                    s.flags.wint = w_int;
                    s.flags.rint = r_int;
                    s.flags.irq  = w_int | r_int;
                    s.latch_c = {i_state.flags.obf, i_state.flags.wie, i_state.flags.ibf,
                                 i_state.flags.rie, w_int | r_int, i_state.latch_c[2:0]};
                end
                res.read_data = s.latch_c;
            end
            ACT_STROBE: begin
                if (m2) begin
                    s.strobe_buf = i_data;
                    s.flags.ibf  = 1'b1;
                    s.flags.rint = 1'b1;
                end
            end
            ACT_ACK: begin
                if (m2) begin
                    s.flags.obf  = 1'b1;
                    s.flags.wint = 1'b1;
                end
                res.read_data = i_state.latch_a;
            end
            default: begin
            end
        endcase

        res.input_full   = (s.mode_a == MODE_A2) & s.flags.ibf;
        res.output_full  = (s.mode_a == MODE_A2) & s.flags.obf;
        res.port_a_value = s.latch_a;
        res.port_b_value = s.latch_b;
        res.port_c_value = s.latch_c;
    end

    assign o_state  = s;
    assign o_result = res;

endmodule

[rtl/parallel_port_with_handshake_core.sv]
// ---------------------------------------------------------------------------
// parallel_port_with_handshake_core
// three-port parallel interface with group a mode-2 handshake flags
// ---------------------------------------------------------------------------
// Each item is one access (host write or read of port a, b, c or control,
// or a peripheral strobe or acknowledge on port a) and returns one result
// item. It is decoded against the port state registers in a single
// combinational pass, the state is updated and the result lands in the
// output register at the same edge, so the block accepts one item per
// clock whenever the output register is empty or is being drained in
// that cycle. Reset puts every port in input mode, clears the latches
// and leaves only the output buffer full flag set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "parallel_port_with_handshake_core_macros.svh"

module parallel_port_with_handshake_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // item in
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_action,
    input  logic [7:0] i_data,
    // item out
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_port_a_written,
    output logic       o_port_b_written,
    output logic       o_port_c_low_written,
    output logic       o_port_c_high_written,
    output logic       o_bit_op_written,
    output logic       o_input_full,
    output logic       o_output_full,
    output logic [7:0] o_port_a_value,
    output logic [7:0] o_port_b_value,
    output logic [7:0] o_port_c_value
);
    import pph_pkg::*;

    // port latches, modes, directions and handshake flags
    t_state  r_state;
    t_state  n_state;
    // result register
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    in_fire;

    // the output register frees up in the same cycle it is taken
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // single-pass decode of the access
    pph_access u_access (
        .i_state  (r_state),
        .i_action (i_action),
        .i_data   (i_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // state only moves when an item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.latch_a    <= '0;
            r_state.latch_b    <= '0;
            r_state.latch_c    <= '0;
            r_state.strobe_buf <= '0;
            r_state.mode_a     <= MODE_A0;
            r_state.mode_b     <= 1'b0;
            r_state.dir        <= 4'hf;
            r_state.flags      <= FLAGS_RESET;
        end else if (in_fire) begin
            r_state <= n_state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_read_data           = r_result.read_data;
    assign o_port_a_written      = r_result.port_a_written;
    assign o_port_b_written      = r_result.port_b_written;
    assign o_port_c_low_written  = r_result.port_c_low_written;
    assign o_port_c_high_written = r_result.port_c_high_written;
    assign o_bit_op_written      = r_result.bit_op_written;
    assign o_input_full          = r_result.input_full;
    assign o_output_full         = r_result.output_full;
    assign o_port_a_value        = r_result.port_a_value;
    assign o_port_b_value        = r_result.port_b_value;
    assign o_port_c_value        = r_result.port_c_value;

    // group a mode code three never occurs
    `PPH_ASSERT(a_mode_a_legal, r_state.mode_a != 2'd3)
    // a pending result reflects the current latches
    `PPH_ASSERT(a_latch_match, o_out_valid |-> (o_port_a_value == r_state.latch_a &&
        o_port_b_value == r_state.latch_b && o_port_c_value == r_state.latch_c))
    // buffer flags shown only in mode 2 and track the flag registers
    `PPH_ASSERT(a_flag_match, o_out_valid |-> (o_input_full ==
        (r_state.mode_a == MODE_A2 && r_state.flags.ibf) && o_output_full ==
        (r_state.mode_a == MODE_A2 && r_state.flags.obf)))
    // one access touches at most one register class
    `PPH_ASSERT(a_write_class, o_out_valid |-> $onehot0({o_port_a_written, o_port_b_written,
        o_port_c_low_written || o_port_c_high_written, o_bit_op_written}))
    // no result pending while in reset
    `PPH_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid)

endmodule

[sim/tb.sv]
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the parallel port with mode-2 handshake
// ---------------------------------------------------------------------------
// Drives host and peripheral accesses into the core over a valid/ready
// channel and predicts every result item with an independent model of the
// port latches, modes, directions and handshake flags. A short directed
// pass walks the reset state, every access kind except the port b read,
// each group mode and the mode-2 protected bits. Random sequences then
// program a mode (mostly mode 2) and follow it with a run of accesses,
// mixed with unprogrammed noise and unused access codes. The sender idles
// in bursts and the receiver stalls in changing patterns, with one long
// receive hold-off and one full drain in the middle of the run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pph_pkg::*;

    localparam int          ITEM_TARGET      = 550;
    localparam int          WATCHDOG_LIMIT   = 2000;
    localparam int          HOLD_OFF_CYCLES  = 60;
    localparam int          SETTLE_CYCLES    = 8;
    localparam logic [3:0]  ACT_UNUSED_LO    = 4'd9;
    localparam logic [3:0]  ACT_UNUSED_HI    = 4'd15;

    // expected-result tracker with its own copy of the port state
    class port_scoreboard;
        logic [7:0] latch_a;
        logic [7:0] latch_b;
        logic [7:0] latch_c;
        logic [7:0] strobe_buf;
        logic [1:0] mode_a;
        logic       mode_b;
        logic [3:0] dir;
        t_flags     flags;
        t_result    expected_q[$];
        int         mismatches;
        int         results_seen;

        function new();
            latch_a      = 8'h00;
            latch_b      = 8'h00;
            latch_c      = 8'h00;
            strobe_buf   = 8'h00;
            mode_a       = MODE_A0;
            mode_b       = 1'b0;
            dir          = 4'hf;
            flags        = FLAGS_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one access against the port state, returns the result item
        function t_result predict_access(logic [3:0] act, logic [7:0] d);
            t_result    res;
            logic       m2;
            logic [2:0] sel;
            logic       w;
            logic       r;
            logic [7:0] wd;
            res = '0;
            wd  = d;
            m2  = (mode_a == MODE_A2);
            case (act)
                ACT_WR_A: begin
                    if (!dir[0]) begin
                        latch_a = d;
                        if (m2) begin
                            flags.wint = 1'b0;
                            flags.obf  = 1'b0;
                        end
                        res.port_a_written = 1'b1;
                    end
                end
                ACT_WR_B: begin
                    if (!dir[1]) begin
                        latch_b = d;
                        res.port_b_written = 1'b1;
                    end
                end
                ACT_WR_C: begin
                    // low three bits follow the data in modes 1 and 2
                    if (mode_a == MODE_A0) begin
                        if (mode_b) wd = {d[7:4], latch_c[3:0]};
                    end else begin
                        latch_c[2:0] = d[2:0];
                        if (mode_b) wd = latch_c;
                    end
                    if (!dir[2] && !mode_b) begin
                        if (mode_a == MODE_A0) latch_c[3:0] = wd[3:0];
                        else                   latch_c[2:0] = wd[2:0];
                        res.port_c_low_written = 1'b1;
                    end
                    if (!dir[3] && mode_a == MODE_A0) begin
                        latch_c[7:3] = wd[7:3];
                        res.port_c_high_written = 1'b1;
                    end
                end
                ACT_WR_CTL: begin
                    if (d[7]) begin
                        // mode set clears the latches, flags are kept
                        mode_a  = d[6] ? MODE_A2 : (d[5] ? MODE_A1 : MODE_A0);
                        mode_b  = d[2];
                        dir     = {d[3], d[0], d[1], d[4]};
                        latch_a = 8'h00;
                        latch_b = 8'h00;
                        latch_c = (mode_a == MODE_A2) ? 8'h80 : 8'h00;
                    end else begin
                        sel = d[3:1];
                        if (m2) begin
                            if (sel == SEL_RIE)        flags.rie = d[0];
                            else if (sel == SEL_WIE)   flags.wie = d[0];
                            else if (sel < SEL_LIMIT)  latch_c[sel] = d[0];
                        end else begin
                            latch_c[sel] = d[0];
                        end
                        res.bit_op_written = 1'b1;
                    end
                end
                ACT_RD_A: begin
                    if (m2) begin
                        flags.rint = 1'b0;
                        if (flags.ibf) latch_a = strobe_buf;
                        flags.ibf = 1'b0;
                    end
                    res.read_data = latch_a;
                end
                ACT_RD_B: res.read_data = latch_b;
                ACT_RD_C: begin
                    if (m2) begin
                        // status byte rebuilt from the flags
                        w          = flags.obf && flags.wie;
                        r          = flags.ibf && flags.rie;
                        flags.wint = w;
                        flags.rint = r;
                        flags.irq  = w || r;
                        latch_c    = {flags.obf, flags.wie, flags.ibf, flags.rie,
                                      w || r, latch_c[2:0]};
                    end
                    res.read_data = latch_c;
                end
                ACT_STROBE: begin
                    if (m2) begin
                        strobe_buf = d;
                        flags.ibf  = 1'b1;
                        flags.rint = 1'b1;
                    end
                end
                ACT_ACK: begin
                    if (m2) begin
                        flags.obf  = 1'b1;
                        flags.wint = 1'b1;
                    end
                    res.read_data = latch_a;
                end
                default: ;
            endcase
            res.input_full   = (mode_a == MODE_A2) && flags.ibf;
            res.output_full  = (mode_a == MODE_A2) && flags.obf;
            res.port_a_value = latch_a;
            res.port_b_value = latch_b;
            res.port_c_value = latch_c;
            return res;
        endfunction

        function void note_access(logic [3:0] act, logic [7:0] d);
            expected_q.push_back(predict_access(act, d));
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: mismatch in %s of result %0d: expected %02h, got %02h",
                             name, results_seen, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: result %0d arrived with nothing expected", results_seen);
            end else begin
                want = expected_q.pop_front();
                compare_field("read_data", want.read_data, got.read_data);
                compare_field("port_a_written", want.port_a_written, got.port_a_written);
                compare_field("port_b_written", want.port_b_written, got.port_b_written);
                compare_field("port_c_low_written", want.port_c_low_written,
                              got.port_c_low_written);
                compare_field("port_c_high_written", want.port_c_high_written,
                              got.port_c_high_written);
                compare_field("bit_op_written", want.bit_op_written, got.bit_op_written);
                compare_field("input_full", want.input_full, got.input_full);
                compare_field("output_full", want.output_full, got.output_full);
                compare_field("port_a_value", want.port_a_value, got.port_a_value);
                compare_field("port_b_value", want.port_b_value, got.port_b_value);
                compare_field("port_c_value", want.port_c_value, got.port_c_value);
            end
            results_seen++;
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [3:0] i_action;
    logic [7:0] i_data;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_read_data;
    logic       o_port_a_written;
    logic       o_port_b_written;
    logic       o_port_c_low_written;
    logic       o_port_c_high_written;
    logic       o_bit_op_written;
    logic       o_input_full;
    logic       o_output_full;
    logic [7:0] o_port_a_value;
    logic [7:0] o_port_b_value;
    logic [7:0] o_port_c_value;

    port_scoreboard sb;
    int             items_sent   = 0;
    int             burst_left   = 0;
    int             idle_cycles  = 0;
    bit             hold_off_req = 1'b0;

    parallel_port_with_handshake_core DUT (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_action              (i_action),
        .i_data                (i_data),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_read_data           (o_read_data),
        .o_port_a_written      (o_port_a_written),
        .o_port_b_written      (o_port_b_written),
        .o_port_c_low_written  (o_port_c_low_written),
        .o_port_c_high_written (o_port_c_high_written),
        .o_bit_op_written      (o_bit_op_written),
        .o_input_full          (o_input_full),
        .o_output_full         (o_output_full),
        .o_port_a_value        (o_port_a_value),
        .o_port_b_value        (o_port_b_value),
        .o_port_c_value        (o_port_c_value)
    );

    always #5 i_clk = ~i_clk;

    // present one item and hold it until the core takes it
    task automatic send_access(input logic [3:0] act, input logic [7:0] d);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_data     <= d;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    // send, then idle between bursts of random length
    task automatic offer_access(input logic [3:0] act, input logic [7:0] d);
        int gap;
        send_access(act, d);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            // now and then a long stretch with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
        end
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // weighted access mix, with a few unused codes
    function automatic logic [3:0] pick_action();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14)      return ACT_WR_A;
        else if (r < 24) return ACT_WR_B;
        else if (r < 34) return ACT_WR_C;
        else if (r < 46) return ACT_WR_CTL;
        else if (r < 58) return ACT_RD_A;
        else if (r < 64) return ACT_RD_B;
        else if (r < 76) return ACT_RD_C;
        else if (r < 86) return ACT_STROBE;
        else if (r < 96) return ACT_ACK;
        else             return 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    endfunction

    // control byte inside a sequence: mostly bit set/reset, rarely a new mode
    function automatic logic [7:0] pick_ctl_byte();
        if ($urandom_range(0, 99) < 85) return {1'b0, 7'($urandom_range(0, 127))};
        else                            return {1'b1, 7'($urandom_range(0, 127))};
    endfunction

    // one sampling point per edge for both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result({o_read_data, o_port_a_written, o_port_b_written,
                                 o_port_c_low_written, o_port_c_high_written,
                                 o_bit_op_written, o_input_full, o_output_full,
                                 o_port_a_value, o_port_b_value, o_port_c_value});
            if (i_in_valid && o_in_ready)
                sb.note_access(i_action, i_data);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: stall style changes after each span of random length
    initial begin : receiver
        int style;
        int span;
        int phase;
        phase = 0;
        i_out_ready <= 1'b0;
        forever begin
            style = $urandom_range(0, 2);
            span  = $urandom_range(30, 150);
            repeat (span) begin
                @(posedge i_clk);
                if (hold_off_req) begin
                    // long hold-off so the core backs up into its input
                    i_out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                    hold_off_req = 1'b0;
                end else begin
                    phase++;
                    case (style)
                        0:       i_out_ready <= 1'b1;
                        1:       i_out_ready <= ($urandom_range(0, 2) != 0);
                        default: i_out_ready <= (phase % 3 == 0);
                    endcase
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("tb: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int         seq_len;
        int         k;
        bit         hold_done;
        bit         pause_done;
        logic [3:0] act;
        logic [7:0] d;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        sb = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_action   <= ACT_RD_A;
        i_data     <= 8'h00;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state: every port is an input, writes are dropped
        offer_access(ACT_RD_A, 8'h00);
        offer_access(ACT_WR_A, 8'hff);
        offer_access(ACT_WR_C, 8'hff);
        offer_access(ACT_STROBE, 8'h5a);     // strobe outside mode 2
        offer_access(ACT_ACK, 8'hff);        // ack outside mode 2 still reads a
        offer_access(ACT_UNUSED_LO, 8'h00);
        offer_access(ACT_UNUSED_HI, 8'hff);
        // mode 0, all outputs
        offer_access(ACT_WR_CTL, 8'h80);
        offer_access(ACT_WR_A, 8'hff);
        offer_access(ACT_WR_B, 8'hff);
        offer_access(ACT_WR_C, 8'ha5);
        offer_access(ACT_WR_CTL, 8'h0f);     // set port c bit 7
        offer_access(ACT_WR_CTL, 8'h00);     // clear port c bit 0
        offer_access(ACT_RD_C, 8'h00);
        // group b mode 1 keeps the low nibble
        offer_access(ACT_WR_CTL, 8'h84);
        offer_access(ACT_WR_C, 8'hff);
        // group a mode 1: low three bits always follow the data
        offer_access(ACT_WR_CTL, 8'ha0);
        offer_access(ACT_WR_C, 8'h3c);
        // group a mode 2 handshake
        offer_access(ACT_WR_CTL, 8'hc0);
        offer_access(ACT_WR_A, 8'h81);
        offer_access(ACT_WR_CTL, 8'h09);     // read interrupt enable on
        offer_access(ACT_WR_CTL, 8'h0d);     // write interrupt enable on
        offer_access(ACT_ACK, 8'h00);
        offer_access(ACT_STROBE, 8'hc3);
        offer_access(ACT_RD_C, 8'h00);
        offer_access(ACT_RD_A, 8'h00);
        offer_access(ACT_WR_CTL, 8'h07);     // protected bit, no effect
        offer_access(ACT_WR_CTL, 8'hff);     // mode 2 with every group an input

        // random sequences: a mode, then a run of accesses
        while (items_sent < ITEM_TARGET) begin
            if (!hold_done && items_sent >= 200) begin
                hold_done    = 1'b1;
                hold_off_req = 1'b1;
                repeat (16) send_access(pick_action(), 8'($urandom_range(0, 255)));
            end
            if (!pause_done && items_sent >= 380) begin
                pause_done = 1'b1;
                wait_for_drain();
            end
            seq_len = $urandom_range(8, 30);
            if ($urandom_range(0, 9) == 0) begin
                // noise: any code, no mode programmed first
                for (k = 0; k < seq_len; k++)
                    offer_access(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 1) == 0) d = {2'b11, 6'($urandom_range(0, 63))};
                else                           d = {1'b1, 7'($urandom_range(0, 127))};
                offer_access(ACT_WR_CTL, d);
                for (k = 0; k < seq_len; k++) begin
                    act = pick_action();
                    d   = (act == ACT_WR_CTL) ? pick_ctl_byte() : 8'($urandom_range(0, 255));
                    offer_access(act, d);
                end
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[parallel_port_with_handshake_core.f]
+incdir+rtl
rtl/pph_pkg.sv
rtl/pph_access.sv
rtl/parallel_port_with_handshake_core.sv
sim/tb.sv
